>>> design/olo_pkg.sv
`default_nettype none

package olo_pkg;

  // Fixed-point formats
  localparam int P_W   = 18;   // pressure factor, Q2.16
  localparam int T_W   = 18;   // temperature factor, Q2.16
  localparam int S_W   = 17;   // sqrt of temperature factor, Q16
  localparam int ADF_W = 20;   // |frequency - line center|
  localparam int M_W   = 32;   // 357 * n
  localparam int Y_W   = 60;   // 100 * D

  localparam logic [P_W-1:0] ONE_Q16 = 18'd65536;

  // Range limits, tested on raw inputs
  localparam logic [18:0] P_LO_X10 = 19'd14016;   // 10 * pressure lower bound
  localparam logic [14:0] P_HI     = 15'd28032;
  localparam logic [15:0] T_LO     = 16'd9600;
  localparam logic [15:0] T_HI     = 16'd38400;

  // pressure * 2^16 / 14016 == (pressure * 2^10) / 219
  localparam logic [24:0] P_RECIP   = 25'd19611722;   // floor(2^32 / 219)
  localparam logic [7:0]  P_DIVQ    = 8'd219;

  // 19200 * 2^16 / temperature: leading partial remainder, divisor for t = 1.0
  localparam logic [15:0] T_REM0    = 16'd4800;
  localparam logic [15:0] T_UNITY   = 16'd19200;

  localparam logic [19:0] LINE_CENTER = 20'd121600;

  // Division by 5 split at bit 18: 2^18 = 5 * 52428 + 4
  localparam logic [22:0] DIV5_RECIP = 23'd6710886;   // floor(2^25 / 5)
  localparam logic [15:0] DIV5_HI    = 16'd52428;

  localparam logic [8:0] OPAC_NUM = 9'd357;
  localparam logic [6:0] OPAC_DEN = 7'd100;

  typedef struct packed {
    logic p_rep;
    logic t_rep;
  } flags_t;

  // Side data riding along the temperature divider
  typedef struct packed {
    logic [P_W-1:0]   p;
    logic [ADF_W-1:0] adf;
    flags_t           flags;
  } tdiv_tag_t;

  // Side data riding along the square root
  typedef struct packed {
    logic [P_W-1:0]   p;
    logic [T_W-1:0]   t;
    logic [ADF_W-1:0] adf;
    flags_t           flags;
  } sq_tag_t;

endpackage

`default_nettype wire

>>> design/olo_div.sv
`default_nettype none

// Pipelined restoring divider. Starts from a partial remainder below the
// divisor and shifts in zero dividend bits; SPS quotient bits per stage.
module olo_div #(
  parameter int DW  = 16,
  parameter int QB  = 18,
  parameter int SPS = 2,
  parameter int TW  = 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [DW-1:0] in_rem,
  input  wire logic [DW-1:0] in_den,
  input  wire logic [TW-1:0] in_tag,
  output logic               out_valid,
  output logic [QB-1:0]      out_quo,
  output logic [TW-1:0]      out_tag
);

  localparam int NS = QB / SPS;

  logic          vld [NS];
  logic [DW-1:0] rem [NS];
  logic [DW-1:0] den [NS];
  logic [QB-1:0] quo [NS];
  logic [TW-1:0] tag [NS];

  logic [DW-1:0] rem_next [NS];
  logic [QB-1:0] quo_next [NS];

  // Per-stage shift/compare/subtract steps
  always_comb begin
    logic [DW-1:0] r;
    logic [DW-1:0] d;
    logic [QB-1:0] q;
    logic [DW:0]   r2;
    for (int g = 0; g < NS; g++) begin
      if (g == 0) begin
        r = in_rem;
        d = in_den;
        q = '0;
      end else begin
        r = rem[g-1];
        d = den[g-1];
        q = quo[g-1];
      end
      for (int j = 0; j < SPS; j++) begin
        r2 = {r, 1'b0};
        if (r2 >= {1'b0, d}) begin
          r2 = r2 - {1'b0, d};
          q  = {q[QB-2:0], 1'b1};
        end else begin
          q  = {q[QB-2:0], 1'b0};
        end
        r = r2[DW-1:0];
      end
      rem_next[g] = r;
      quo_next[g] = q;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NS; g++) vld[g] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int g = 1; g < NS; g++) vld[g] <= vld[g-1];
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NS; g++) begin
        rem[g] <= rem_next[g];
        quo[g] <= quo_next[g];
      end
      den[0] <= in_den;
      tag[0] <= in_tag;
      for (int g = 1; g < NS; g++) begin
        den[g] <= den[g-1];
        tag[g] <= tag[g-1];
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_quo   = quo[NS-1];
  assign out_tag   = tag[NS-1];

endmodule

`default_nettype wire

>>> design/olo_sqrt.sv
`default_nettype none

// Pipelined digit-by-digit square root of t * 2^16, two result bits per stage.
module olo_sqrt #(
  parameter int TW = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_valid,
  input  wire logic [olo_pkg::T_W-1:0] in_t,
  input  wire logic [TW-1:0]          in_tag,
  output logic                        out_valid,
  output logic [olo_pkg::S_W-1:0]     out_s,
  output logic [TW-1:0]               out_tag
);

  // Radicand {2'b0, t, 16'b0}: 18 bit pairs
  localparam int NS  = 9;
  localparam int SPS = 2;
  localparam int VW  = 36;
  localparam int RW  = 20;
  localparam int QW  = 18;

  logic                    vld  [NS];
  logic [RW-1:0]           rem  [NS];
  logic [QW-1:0]           root [NS];
  logic [olo_pkg::T_W-1:0] tv   [NS];
  logic [TW-1:0]           tag  [NS];

  logic [RW-1:0] rem_next  [NS];
  logic [QW-1:0] root_next [NS];

  always_comb begin
    logic [RW-1:0]           r;
    logic [QW-1:0]           q;
    logic [olo_pkg::T_W-1:0] t;
    logic [VW-1:0]           vv;
    logic [RW+1:0]           r4;
    logic [RW+1:0]           trial;
    for (int g = 0; g < NS; g++) begin
      if (g == 0) begin
        r = '0;
        q = '0;
        t = in_t;
      end else begin
        r = rem[g-1];
        q = root[g-1];
        t = tv[g-1];
      end
      vv = {2'b00, t, 16'b0};
      for (int j = 0; j < SPS; j++) begin
        r4    = {r, vv[VW-1-2*(g*SPS+j) -: 2]};
        trial = {2'b00, q, 2'b01};
        if (r4 >= trial) begin
          r4 = r4 - trial;
          q  = {q[QW-2:0], 1'b1};
        end else begin
          q  = {q[QW-2:0], 1'b0};
        end
        r = r4[RW-1:0];
      end
      rem_next[g]  = r;
      root_next[g] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g < NS; g++) vld[g] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int g = 1; g < NS; g++) vld[g] <= vld[g-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < NS; g++) begin
        rem[g]  <= rem_next[g];
        root[g] <= root_next[g];
      end
      tv[0]  <= in_t;
      tag[0] <= in_tag;
      for (int g = 1; g < NS; g++) begin
        tv[g]  <= tv[g-1];
        tag[g] <= tag[g-1];
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign out_s     = root[NS-1][olo_pkg::S_W-1:0];
  assign out_tag   = tag[NS-1];

endmodule

`default_nettype wire

>>> design/olo_poly.sv
`default_nettype none

// Product and line-shape terms: numerator m = 357 * p^2 t^2.5 and
// denominator y = 100 * ((f - 118.75)^2 + 1.4 p sqrt(t)), five stages.
module olo_poly (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic [olo_pkg::P_W-1:0]   p,
  input  wire logic [olo_pkg::T_W-1:0]   t,
  input  wire logic [olo_pkg::S_W-1:0]   s,
  input  wire logic [olo_pkg::ADF_W-1:0] adf,
  input  wire olo_pkg::flags_t           in_flags,
  output logic                          out_valid,
  output logic [olo_pkg::M_W-1:0]       m,
  output logic [olo_pkg::Y_W-1:0]       y,
  output olo_pkg::flags_t               out_flags
);

  logic v1, v2, v3, v4, v5;

  // Stage 1: squares and p*s
  logic [18:0]               a1, b1;
  logic [34:0]               ps1;
  logic [39:0]               adf2_1;
  logic [olo_pkg::S_W-1:0]   s1;
  olo_pkg::flags_t           f1;
  logic [35:0]               pp, tt;

  assign pp = 36'(p) * 36'(p);
  assign tt = 36'(t) * 36'(t);

  // Stage 2: c = a*b, split 7*p*s for the divide by 5
  logic [21:0]             c2;
  logic [19:0]             xh2;
  logic [22:0]             xv2;
  logic [51:0]             dbase2;
  logic [olo_pkg::S_W-1:0] s2;
  olo_pkg::flags_t         f2;
  logic [37:0]             ab, x7;

  assign ab = 38'(a1) * 38'(b1);
  assign x7 = 38'(ps1) * 38'(7);

  // Stage 3: n = c*s, reciprocal estimate of the low part / 5
  logic [22:0]     n3;
  logic [20:0]     q5_3;
  logic [35:0]     xk3;
  logic [22:0]     xv3;
  logic [51:0]     dbase3;
  olo_pkg::flags_t f3;
  logic [38:0]     cs;
  logic [45:0]     xr;

  assign cs = 39'(c2) * 39'(s2);
  assign xr = 46'(xv2) * 46'(olo_pkg::DIV5_RECIP);

  // Stage 4: numerator, corrected quotient, denominator sum
  logic [olo_pkg::M_W-1:0] m4;
  logic [52:0]             d4;
  olo_pkg::flags_t         f4;
  logic [22:0]             rem5;
  logic [20:0]             q5;

  assign rem5 = xv3 - 23'(23'(q5_3) * 23'(5));
  assign q5   = q5_3 + 21'(rem5 >= 23'd5);

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
    end else if (en) begin
      {v1, v2, v3, v4, v5} <= {in_valid, v1, v2, v3, v4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1     <= pp[34:16];
      b1     <= tt[34:16];
      ps1    <= 35'(35'(p) * 35'(s));
      adf2_1 <= 40'(adf) * 40'(adf);
      s1     <= s;
      f1     <= in_flags;

      c2     <= ab[37:16];
      xh2    <= x7[37:18];
      xv2    <= {1'b0, x7[37:18], 2'b00} + 23'(x7[17:0]);
      dbase2 <= {adf2_1, 12'b0};
      s2     <= s1;
      f2     <= f1;

      n3     <= cs[38:16];
      q5_3   <= xr[45:25];
      xk3    <= 36'(xh2) * 36'(olo_pkg::DIV5_HI);
      xv3    <= xv2;
      dbase3 <= dbase2;
      f3     <= f2;

      m4     <= olo_pkg::M_W'(n3) * olo_pkg::M_W'(olo_pkg::OPAC_NUM);
      d4     <= 53'(dbase3) + 53'(xk3) + 53'(q5);
      f4     <= f3;

      m         <= m4;
      y         <= olo_pkg::Y_W'(d4) * olo_pkg::Y_W'(olo_pkg::OPAC_DEN);
      out_flags <= f4;
    end
  end

  assign out_valid = v5;

endmodule

`default_nettype wire

>>> design/oxygen_line_opacity_unit.sv
`default_nettype none

// Oxygen 118.75 GHz line zenith opacity.
// Input channel (sample_valid / sample_stall): frequency in 1/1024 GHz,
// temperature in 1/64 K, pressure in 1/16 mbar. Output channel
// (result_valid / result_stall): opacity in Q7.OUT_FRAC_BITS, capped at
// 100.0, plus flags for a replaced pressure factor, a replaced temperature
// factor and a capped opacity. One result per sample, in order.
// Throughput: one sample per cycle while sample_stall is low. A sample
// passes from the accepting edge to result_valid through the input
// and range registers, the 9-stage temperature divider, 9-stage square root,
// 5 arithmetic stages, the one-bit-per-stage opacity divider
// (16 + OUT_FRAC_BITS stages) and the output register.
// Reset clears every valid bit; no result is pending afterward.
// When result_stall holds off a result, the next finished result goes into
// a skid register and the whole pipeline freezes; sample_stall is high
// exactly while that skid register is full.
module oxygen_line_opacity_unit #(
  parameter int OUT_FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       sample_valid,
  output logic                            sample_stall,
  input  wire logic [19:0]                frequency,
  input  wire logic [15:0]                temperature,
  input  wire logic [14:0]                pressure,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic [6+OUT_FRAC_BITS:0]        opacity,
  output logic                            pressure_replaced,
  output logic                            temperature_replaced,
  output logic                            opacity_capped
);

  localparam int OUT_W = 7 + OUT_FRAC_BITS;
  localparam int QB    = 16 + OUT_FRAC_BITS;
  localparam logic [QB-1:0]    CAP_Q   = QB'(100) << OUT_FRAC_BITS;
  localparam logic [OUT_W-1:0] CAP_OUT = OUT_W'(100) << OUT_FRAC_BITS;

  logic en;
  logic skid_v;

  assign en           = !skid_v;
  assign sample_stall = skid_v;

  // Stage A: input register
  logic        a_v;
  logic [19:0] a_f;
  logic [15:0] a_tk;
  logic [14:0] a_pm;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (en) begin
      a_v <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_f  <= frequency;
      a_tk <= temperature;
      a_pm <= pressure;
    end
  end

  // Stage B: range tests, offset from line center, pressure estimate
  logic                          b_v;
  logic [olo_pkg::ADF_W-1:0]     b_adf;
  olo_pkg::flags_t               b_flags;
  logic [15:0]                   b_dsel;
  logic [14:0]                   b_pm;
  logic [olo_pkg::P_W-1:0]       b_p0;
  logic                          a_prep, a_trep;
  logic [49:0]                   a_pprod;

  assign a_prep  = (19'(a_pm) * 19'd10 < olo_pkg::P_LO_X10) || (a_pm > olo_pkg::P_HI);
  assign a_trep  = (a_tk < olo_pkg::T_LO) || (a_tk > olo_pkg::T_HI);
  assign a_pprod = 50'({a_pm, 10'b0}) * 50'(olo_pkg::P_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (en) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_adf         <= (a_f >= olo_pkg::LINE_CENTER) ? a_f - olo_pkg::LINE_CENTER
                                                     : olo_pkg::LINE_CENTER - a_f;
      b_flags.p_rep <= a_prep;
      b_flags.t_rep <= a_trep;
      b_dsel        <= a_trep ? olo_pkg::T_UNITY : a_tk;
      b_pm          <= a_pm;
      b_p0          <= a_pprod[49:32];
    end
  end

  // Pressure quotient correction and substitution
  logic [25:0]             p_rem;
  logic [olo_pkg::P_W-1:0] p_val;
  olo_pkg::tdiv_tag_t      td_in_tag, td_out_tag;

  assign p_rem = 26'({b_pm, 10'b0}) - 26'(26'(b_p0) * 26'(olo_pkg::P_DIVQ));
  assign p_val = b_flags.p_rep ? olo_pkg::ONE_Q16
                               : b_p0 + olo_pkg::P_W'(p_rem >= 26'(olo_pkg::P_DIVQ));

  assign td_in_tag.p     = p_val;
  assign td_in_tag.adf   = b_adf;
  assign td_in_tag.flags = b_flags;

  // Temperature factor t = 19200 * 2^16 / temperature, or 1.0 when replaced
  logic                    td_v;
  logic [olo_pkg::T_W-1:0] td_t;

  olo_div #(
    .DW  (16),
    .QB  (olo_pkg::T_W),
    .SPS (2),
    .TW  ($bits(olo_pkg::tdiv_tag_t))
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (b_v),
    .in_rem    (olo_pkg::T_REM0),
    .in_den    (b_dsel),
    .in_tag    (td_in_tag),
    .out_valid (td_v),
    .out_quo   (td_t),
    .out_tag   (td_out_tag)
  );

  // Square root of t
  olo_pkg::sq_tag_t        sq_in_tag, sq_out_tag;
  logic                    sq_v;
  logic [olo_pkg::S_W-1:0] sq_s;

  assign sq_in_tag.p     = td_out_tag.p;
  assign sq_in_tag.t     = td_t;
  assign sq_in_tag.adf   = td_out_tag.adf;
  assign sq_in_tag.flags = td_out_tag.flags;

  olo_sqrt #(
    .TW ($bits(olo_pkg::sq_tag_t))
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (td_v),
    .in_t      (td_t),
    .in_tag    (sq_in_tag),
    .out_valid (sq_v),
    .out_s     (sq_s),
    .out_tag   (sq_out_tag)
  );

  // Numerator and denominator
  logic                    pl_v;
  logic [olo_pkg::M_W-1:0] pl_m;
  logic [olo_pkg::Y_W-1:0] pl_y;
  olo_pkg::flags_t         pl_flags;

  olo_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sq_v),
    .p         (sq_out_tag.p),
    .t         (sq_out_tag.t),
    .s         (sq_s),
    .adf       (sq_out_tag.adf),
    .in_flags  (sq_out_tag.flags),
    .out_valid (pl_v),
    .m         (pl_m),
    .y         (pl_y),
    .out_flags (pl_flags)
  );

  // Opacity quotient; m < y always, so only fraction bits are developed
  logic            od_v;
  logic [QB-1:0]   od_q;
  olo_pkg::flags_t od_flags;

  olo_div #(
    .DW  (olo_pkg::Y_W),
    .QB  (QB),
    .SPS (1),
    .TW  ($bits(olo_pkg::flags_t))
  ) u_odiv (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pl_v),
    .in_rem    (olo_pkg::Y_W'(pl_m)),
    .in_den    (pl_y),
    .in_tag    (pl_flags),
    .out_valid (od_v),
    .out_quo   (od_q),
    .out_tag   (od_flags)
  );

  // Saturation
  logic             res_cap;
  logic [OUT_W-1:0] res_opac;

  assign res_cap  = od_q > CAP_Q;
  assign res_opac = res_cap ? CAP_OUT : od_q[OUT_W-1:0];

  // Output register and skid register
  logic [OUT_W-1:0] skid_opac;
  olo_pkg::flags_t  skid_flags;
  logic             skid_cap;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_v       <= 1'b0;
    end else if (!result_valid || !result_stall) begin
      if (skid_v) begin
        result_valid <= 1'b1;
        skid_v       <= 1'b0;
      end else begin
        result_valid <= od_v;
      end
    end else if (od_v && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!result_valid || !result_stall) begin
      if (skid_v) begin
        opacity              <= skid_opac;
        pressure_replaced    <= skid_flags.p_rep;
        temperature_replaced <= skid_flags.t_rep;
        opacity_capped       <= skid_cap;
      end else begin
        opacity              <= res_opac;
        pressure_replaced    <= od_flags.p_rep;
        temperature_replaced <= od_flags.t_rep;
        opacity_capped       <= res_cap;
      end
    end else if (od_v && en) begin
      skid_opac  <= res_opac;
      skid_flags <= od_flags;
      skid_cap   <= res_cap;
    end
  end

  // Checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> result_valid)
    else $error("skid register full while output register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_v) |-> $past(result_valid) && $past(result_stall))
    else $error("skid register filled without a stalled output");

  a_cap_value: assert property (@(posedge clk) disable iff (rst)
    result_valid && opacity_capped |-> opacity == CAP_OUT)
    else $error("capped opacity is not the cap value");

  a_cap_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> opacity <= CAP_OUT)
    else $error("opacity above the cap");

endmodule

`default_nettype wire

>>> tb/tb_oxygen_line_opacity_unit.sv
`timescale 1ns / 100ps

module tb_oxygen_line_opacity_unit;

  localparam int FRAC = 16;
  localparam int OPAC_W = 7 + FRAC;
  localparam int LATENCY = 42 + FRAC;
  localparam longint unsigned CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [19:0] frequency;
    logic [15:0] temperature;
    logic [14:0] pressure;
  } sample_t;

  typedef struct {
    logic [OPAC_W-1:0] opacity;
    logic              p_rep;
    logic              t_rep;
    logic              capped;
  } opacity_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [19:0] frequency = '0;
  logic [15:0] temperature = '0;
  logic [14:0] pressure = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [OPAC_W-1:0] opacity;
  logic pressure_replaced;
  logic temperature_replaced;
  logic opacity_capped;

  sample_t  pending_samples[$];
  opacity_t expected_opacity[$];
  int       mismatch_count = 0;
  int       send_gap = 0;
  int       stall_left = 0;
  longint unsigned cycle_count = 0;

  oxygen_line_opacity_unit #(.OUT_FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .frequency(frequency), .temperature(temperature), .pressure(pressure),
    .result_valid(result_valid), .result_stall(result_stall),
    .opacity(opacity), .pressure_replaced(pressure_replaced),
    .temperature_replaced(temperature_replaced), .opacity_capped(opacity_capped)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // opacity of the oxygen line for one sample
  function automatic opacity_t line_opacity(sample_t smp);
    opacity_t r;
    longint unsigned pf, tf, sq, a, b, c, n, adf, den, num, q, cap;
    r.p_rep = (smp.pressure * 64'd10 < 64'd14016) || (smp.pressure > 15'd28032);
    r.t_rep = (smp.temperature < 16'd9600) || (smp.temperature > 16'd38400);
    pf = r.p_rep ? 64'd65536 : (64'(smp.pressure) << 16) / 64'd14016;
    tf = r.t_rep ? 64'd65536 : (64'd19200 << 16) / 64'(smp.temperature);
    sq = int_sqrt(tf << 16);
    a = (pf * pf) >> 16;
    b = (tf * tf) >> 16;
    c = (a * b) >> 16;
    n = (c * sq) >> 16;
    adf = (smp.frequency >= 20'd121600) ? 64'(smp.frequency) - 64'd121600
                                        : 64'd121600 - 64'(smp.frequency);
    den = ((adf * adf) << 12) + (64'd7 * pf * sq) / 64'd5;
    cap = 64'd100 << FRAC;
    r.capped = 1'b0;
    if (den == 0) begin
      q = cap;
      r.capped = 1'b1;
    end else begin
      num = 64'd357 * n;
      q = (num << (16 + FRAC)) / (64'd100 * den);
      if (q > cap) begin
        q = cap;
        r.capped = 1'b1;
      end
    end
    r.opacity = q[OPAC_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatch_count++;
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
  endtask

  task automatic queue_sample(int f, int tk, int pm);
    sample_t s;
    s.frequency = 20'(f);
    s.temperature = 16'(tk);
    s.pressure = 15'(pm);
    pending_samples.push_back(s);
  endtask

  // mostly physical values near the line, some anywhere in the field range
  task automatic queue_random_sample();
    int f, tk, pm;
    case ($urandom_range(0, 3))
      0: f = $urandom_range(0, 1048575);
      1: f = $urandom_range(121600 - 64, 121600 + 64);
      default: f = $urandom_range(121600 - 20000, 121600 + 20000);
    endcase
    tk = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535) : $urandom_range(9600, 38400);
    pm = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(1402, 28032);
    queue_sample(f, tk, pm);
  endtask

  // input driver: one transaction per accept, random idle bursts
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        expected_opacity.push_back(line_opacity('{frequency, temperature, pressure}));
      end
      if (!sample_valid || !sample_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0) begin
          sample_t s;
          s = pending_samples.pop_front();
          sample_valid <= 1'b1;
          frequency <= s.frequency;
          temperature <= s.temperature;
          pressure <= s.pressure;
          if (pending_samples.size() > 200 && $urandom_range(0, 9) == 0)
            send_gap <= $urandom_range(1, 11);
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and stall bursts
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (expected_opacity.size() == 0) begin
          report_mismatch("unexpected transaction", opacity, 0);
        end else begin
          opacity_t e;
          e = expected_opacity.pop_front();
          if (opacity !== e.opacity) report_mismatch("opacity", opacity, e.opacity);
          if (pressure_replaced !== e.p_rep)
            report_mismatch("pressure_replaced", pressure_replaced, e.p_rep);
          if (temperature_replaced !== e.t_rep)
            report_mismatch("temperature_replaced", temperature_replaced, e.t_rep);
          if (opacity_capped !== e.capped)
            report_mismatch("opacity_capped", opacity_capped, e.capped);
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        result_stall <= 1'b1;
      end else if (pending_samples.size() > 200 && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 10);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    // range edges of both factors, zero temperature, line center, field extremes
    queue_sample(121600, 19200, 14016);
    queue_sample(0, 0, 0);
    queue_sample(1048575, 65535, 32767);
    queue_sample(121600, 9599, 1401);
    queue_sample(121600, 9600, 1402);
    queue_sample(121600, 38400, 28032);
    queue_sample(121600, 38401, 28033);
    queue_sample(121600, 9600, 28032);
    queue_sample(121600, 38400, 1402);
    queue_sample(121601, 0, 14016);
    queue_sample(121599, 1, 14016);
    queue_sample(0, 19200, 28032);
    queue_sample(1048575, 9600, 1402);
    queue_sample(524288, 32768, 16384);
    queue_sample(121600, 65535, 0);
    for (int i = 0; i < 2000; i++) queue_random_sample();

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (pending_samples.size() > 0 || sample_valid || expected_opacity.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatch_count == 0 && expected_opacity.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> oxygen_line_opacity_unit.f
design/olo_pkg.sv
design/olo_div.sv
design/olo_sqrt.sv
design/olo_poly.sv
design/oxygen_line_opacity_unit.sv
tb/tb_oxygen_line_opacity_unit.sv
